/* sv/prrs_pkg.sv */
`default_nettype none
package prrs_pkg;

  localparam int unsigned TaskSlotsDef = 12;
  localparam int unsigned QueueDepth   = 2;

  typedef enum logic [1:0] {
    OP_SUBMIT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_POLL   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_NOT_FOUND = 2'd0,
    ST_PENDING   = 2'd1,
    ST_RUNNING   = 2'd2,
    ST_COMPLETE  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [30:0]        task_id;
    logic               query_active;
    logic [1:0]         priority_req;
    logic [15:0]        file_handle;
    logic [31:0]        buffer_address;
    logic signed [31:0] file_offset;
    logic signed [31:0] byte_count;
    logic               device_busy;
    logic               continue_chain;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic [30:0] new_task_id;
    logic [1:0]  task_status;
    logic [30:0] bytes_read;
    logic        start_valid;
    logic [15:0] start_handle;
    logic [31:0] start_buffer;
    logic [30:0] start_offset;
    logic [30:0] start_length;
    logic        overflow;
  } rsp_t;

  // Classified command handed from the front end to the engine.
  typedef struct packed {
    op_e         op;
    logic        bad;
    logic [30:0] task_id;
    logic        query_active;
    logic [1:0]  prio;
    logic [15:0] handle;
    logic [31:0] buffer;
    logic [30:0] offset;
    logic [30:0] length;
    logic        busy;
    logic        chain;
  } cmd_t;

endpackage
`default_nettype wire

/* sv/prrs_front.sv */
`default_nettype none
module prrs_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire prrs_pkg::req_t  req_i,
  output logic                 cmd_valid_o,
  output prrs_pkg::cmd_t       cmd_o,
  input  wire logic            cmd_pop_i
);
  import prrs_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  cmd_t            cls;

  // Only one item is in flight at a time: results depend on all prior state.
  assign busy        = (cnt_q != '0) || cmd_pop_i;
  assign push        = start && !busy;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_q];

  always_comb begin
    cls.op           = op_e'(req_i.operation);
    cls.bad          = req_i.file_offset[31] || req_i.byte_count[31] ||
                       (req_i.byte_count == '0);
    cls.task_id      = req_i.task_id;
    cls.query_active = req_i.query_active;
    cls.prio         = req_i.priority_req;
    cls.handle       = req_i.file_handle;
    cls.buffer       = req_i.buffer_address;
    cls.offset       = req_i.file_offset[30:0];
    cls.length       = req_i.byte_count[30:0];
    cls.busy         = req_i.device_busy;
    cls.chain        = req_i.continue_chain;
  end

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (cmd_pop_i) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cls;
    end
  end

endmodule
`default_nettype wire

/* sv/prrs_engine.sv */
`default_nettype none
module prrs_engine #(
  parameter int unsigned TaskSlots = prrs_pkg::TaskSlotsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  input  wire prrs_pkg::cmd_t  cmd_i,
  output logic                 cmd_pop_o,
  output logic                 rsp_valid_o,
  output prrs_pkg::rsp_t       rsp_o
);
  import prrs_pkg::*;

  localparam int unsigned SW = $clog2(TaskSlots + 1);
  localparam logic [SW-1:0] Nil = SW'(TaskSlots);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_FREE   = 7'b0000010,
    S_INSERT = 7'b0000100,
    S_QWALK  = 7'b0001000,
    S_DSCAN  = 7'b0010000,
    S_ADV    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_e;

  state_e          st_q, st_d;
  logic [TaskSlots-1:0] av_q, av_d, run_q, run_d, dv_q, dv_d;
  logic [30:0]     aid_q [TaskSlots];
  logic [1:0]      apr_q [TaskSlots];
  logic [15:0]     ahd_q [TaskSlots];
  logic [31:0]     abf_q [TaskSlots];
  logic [30:0]     aof_q [TaskSlots];
  logic [30:0]     aln_q [TaskSlots];
  logic [SW-1:0]   lnk_q [TaskSlots];
  logic [30:0]     did_q [TaskSlots];
  logic [30:0]     dln_q [TaskSlots];
  logic [SW-1:0]   head_q, head_d;
  logic [30:0]     idc_q, idc_d;
  logic [SW-1:0]   idx_q, idx_d, cur_q, cur_d, prev_q, prev_d, slot_q, slot_d;
  rsp_t            rsp_q, rsp_d;

  logic            a_we, l_we, d_we;
  logic [SW-1:0]   a_idx, l_idx, l_val, d_idx;
  logic [30:0]     d_id, d_len;
  logic [30:0]     idn;

  logic [$clog2(TaskSlots)-1:0] ci, ii, hi;
  assign ci = cur_q[$clog2(TaskSlots)-1:0];
  assign ii = idx_q[$clog2(TaskSlots)-1:0];
  assign hi = head_q[$clog2(TaskSlots)-1:0];

  assign rsp_valid_o = (st_q == S_OUT);
  assign rsp_o       = rsp_q;
  assign cmd_pop_o   = (st_q == S_OUT);

  always_comb begin
    st_d   = st_q;
    av_d   = av_q;
    run_d  = run_q;
    dv_d   = dv_q;
    head_d = head_q;
    idc_d  = idc_q;
    idx_d  = idx_q;
    cur_d  = cur_q;
    prev_d = prev_q;
    slot_d = slot_q;
    rsp_d  = rsp_q;
    a_we   = 1'b0;
    a_idx  = slot_q;
    l_we   = 1'b0;
    l_idx  = slot_q;
    l_val  = Nil;
    d_we   = 1'b0;
    d_idx  = idx_q;
    d_id   = aid_q[hi];
    d_len  = aln_q[hi];
    idn    = (idc_q == 31'h7FFFFFFF) ? 31'd1 : idc_q + 31'd1;
    unique case (st_q)
      S_IDLE: begin
        rsp_d = '0;
        idx_d = '0;
        cur_d = head_q;
        prev_d = Nil;
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_SUBMIT: st_d = cmd_i.bad ? S_OUT : S_FREE;
            OP_QUERY: begin
              if (cmd_i.query_active) begin
                if (head_q != Nil) begin
                  rsp_d.task_status = run_q[hi] ? ST_RUNNING : ST_PENDING;
                  rsp_d.bytes_read  = aln_q[hi];
                end
                st_d = S_ADV;
              end else begin
                st_d = S_QWALK;
              end
            end
            OP_POLL: st_d = S_ADV;
            default: st_d = S_OUT;
          endcase
        end
      end
      S_FREE: begin
        if (idx_q == Nil) begin
          rsp_d.overflow = 1'b1;
          st_d = S_OUT;
        end else if (!av_q[ii]) begin
          slot_d = idx_q;
          idc_d  = idn;
          a_we   = 1'b1;
          a_idx  = idx_q;
          av_d[ii]  = 1'b1;
          run_d[ii] = 1'b0;
          rsp_d.accepted    = 1'b1;
          rsp_d.new_task_id = idn;
          idx_d = '0;
          st_d  = S_INSERT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_INSERT: begin
        if (cur_q == Nil || idx_q == Nil ||
            (cmd_i.prio > apr_q[ci] && !run_q[ci])) begin
          l_we  = 1'b1;
          l_idx = slot_q;
          l_val = cur_q;
          if (prev_q == Nil) begin
            head_d = slot_q;
            run_d[slot_q[$clog2(TaskSlots)-1:0]] = 1'b1;
            rsp_d.start_valid  = 1'b1;
            rsp_d.start_handle = cmd_i.handle;
            rsp_d.start_buffer = cmd_i.buffer;
            rsp_d.start_offset = cmd_i.offset;
            rsp_d.start_length = cmd_i.length;
            st_d = S_OUT;
          end else begin
            st_d = S_ADV;
          end
        end else begin
          prev_d = cur_q;
          cur_d  = lnk_q[ci];
          idx_d  = idx_q + 1'b1;
        end
      end
      S_QWALK: begin
        if (cur_q == Nil || idx_q == Nil) begin
          idx_d = '0;
          st_d  = S_DSCAN;
        end else if (aid_q[ci] == cmd_i.task_id) begin
          rsp_d.task_status = run_q[ci] ? ST_RUNNING : ST_PENDING;
          rsp_d.bytes_read  = aln_q[ci];
          idx_d = '0;
          st_d = S_ADV;
        end else begin
          cur_d = lnk_q[ci];
          idx_d = idx_q + 1'b1;
        end
      end
      S_DSCAN: begin
        if (idx_q == Nil) begin
          idx_d = '0;
          st_d = S_ADV;
        end else if (dv_q[ii] && did_q[ii] == cmd_i.task_id) begin
          rsp_d.task_status = ST_COMPLETE;
          rsp_d.bytes_read  = dln_q[ii];
          dv_d[ii] = 1'b0;
          idx_d = '0;
          st_d = S_ADV;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_ADV: begin
        // Link the new entry after prev, or retire the head and chain on.
        if (cmd_i.op == OP_SUBMIT) begin
          l_we  = 1'b1;
          l_idx = prev_q;
          l_val = slot_q;
          st_d  = S_OUT;
        end else if (head_q == Nil || cmd_i.busy) begin
          st_d = S_OUT;
        end else if (idx_q == Nil || dv_q == '1) begin
          if (idx_q != Nil) begin
            rsp_d.overflow = 1'b1;
          end
          head_d   = lnk_q[hi];
          av_d[hi] = 1'b0;
          run_d[hi] = 1'b0;
          st_d     = S_OUT;
          if ((cmd_i.op == OP_QUERY || cmd_i.chain) && lnk_q[hi] != Nil) begin
            run_d[lnk_q[hi][$clog2(TaskSlots)-1:0]] = 1'b1;
            rsp_d.start_valid  = 1'b1;
            rsp_d.start_handle = ahd_q[lnk_q[hi][$clog2(TaskSlots)-1:0]];
            rsp_d.start_buffer = abf_q[lnk_q[hi][$clog2(TaskSlots)-1:0]];
            rsp_d.start_offset = aof_q[lnk_q[hi][$clog2(TaskSlots)-1:0]];
            rsp_d.start_length = aln_q[lnk_q[hi][$clog2(TaskSlots)-1:0]];
          end
        end else if (!dv_q[ii]) begin
          d_we  = 1'b1;
          d_idx = idx_q;
          dv_d[ii] = 1'b1;
          idx_d = Nil;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_OUT: begin
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      av_q   <= '0;
      run_q  <= '0;
      dv_q   <= '0;
      head_q <= Nil;
      idc_q  <= '0;
      idx_q  <= '0;
      cur_q  <= Nil;
      prev_q <= Nil;
      slot_q <= Nil;
      rsp_q  <= '0;
    end else begin
      st_q   <= st_d;
      av_q   <= av_d;
      run_q  <= run_d;
      dv_q   <= dv_d;
      head_q <= head_d;
      idc_q  <= idc_d;
      idx_q  <= idx_d;
      cur_q  <= cur_d;
      prev_q <= prev_d;
      slot_q <= slot_d;
      rsp_q  <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      aid_q[a_idx[$clog2(TaskSlots)-1:0]] <= idn;
      apr_q[a_idx[$clog2(TaskSlots)-1:0]] <= cmd_i.prio;
      ahd_q[a_idx[$clog2(TaskSlots)-1:0]] <= cmd_i.handle;
      abf_q[a_idx[$clog2(TaskSlots)-1:0]] <= cmd_i.buffer;
      aof_q[a_idx[$clog2(TaskSlots)-1:0]] <= cmd_i.offset;
      aln_q[a_idx[$clog2(TaskSlots)-1:0]] <= cmd_i.length;
    end
    if (l_we) begin
      lnk_q[l_idx[$clog2(TaskSlots)-1:0]] <= l_val;
    end
    if (d_we) begin
      did_q[d_idx[$clog2(TaskSlots)-1:0]] <= d_id;
      dln_q[d_idx[$clog2(TaskSlots)-1:0]] <= d_len;
    end
  end

endmodule
`default_nettype wire

/* sv/priority_read_request_scheduler.sv */
// A transaction runs through the slot search, the ordered list walk, the completed-list scan and free-slot search,
// as its operation needs, before its result shows.
// Only one transaction is handled at a time; busy stays high until its result edge.
// The receiver cannot stall: each result shows for one cycle on rsp_valid_o.
// Reset (rst_ni low, asynchronous) empties both lists and zeroes the id counter.
`default_nettype none
module priority_read_request_scheduler #(
  parameter int unsigned TaskSlots = prrs_pkg::TaskSlotsDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire prrs_pkg::req_t  req_i,
  output logic                 rsp_valid_o,
  output prrs_pkg::rsp_t       rsp_o
);
  import prrs_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  prrs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  prrs_engine #(.TaskSlots(TaskSlots)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule
`default_nettype wire

/* sv/prrs_checker.sv */
`default_nettype none
module prrs_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           rsp_valid_o,
  input wire prrs_pkg::rsp_t rsp_o
);
  import prrs_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accept without busy");
  a_rsp_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !rsp_valid_o) else $error("result repeated");
  a_rsp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> busy) else $error("result without transaction");
  a_acc_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.accepted) |-> (rsp_o.new_task_id != '0))
    else $error("zero id given");
  a_acc_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.accepted) |-> !rsp_o.overflow)
    else $error("accepted with overflow");

endmodule

bind priority_read_request_scheduler prrs_checker u_prrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .rsp_valid_o (rsp_valid_o),
  .rsp_o       (rsp_o)
);
`default_nettype wire
